@@ rtl/mpsa_pkg.sv @@
package mpsa_pkg;

  // request operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK            = 2'd0;
  localparam logic [1:0] STAT_EXHAUSTED     = 2'd1;
  localparam logic [1:0] STAT_NOT_IN_USE    = 2'd2;
  localparam logic [1:0] STAT_FREE_REJECTED = 2'd3;

  // back-end memory command kinds
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // stack address field wide enough for 16 pools of 4096 slots
  localparam int CMD_AW = 16;

  localparam logic [3:0] POOLS_IN_USE_RST = 4'd8;

  typedef struct packed {
    logic       operation;
    logic       auto_pool;
    logic [2:0] pool;
    logic [7:0] slot;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] granted_pool;
    logic [7:0] granted_slot;
    logic [8:0] active_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CMD_AW-1:0] addr;
    logic [7:0]        wdata;
    rsp_t              rsp;
  } cmd_t;

endpackage

@@ rtl/mpsa_fifo.sv @@
module mpsa_fifo #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PTRW-1:0] LAST = PTRW'(DEPTH - 1);
  localparam logic [CNTW-1:0] FULL_CNT = CNTW'(DEPTH);

  T                data_q [DEPTH];
  logic [PTRW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/mpsa_front.sv @@
module mpsa_front #(
  parameter int POOLS = 8,
  parameter int SLOTS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [3:0]      cfg_wdata_i,
  input  logic            push_i,
  input  mpsa_pkg::req_t  req_i,
  output logic            full_o,
  output logic            cmd_push_o,
  output mpsa_pkg::cmd_t  cmd_o,
  input  logic            cmd_full_i
);
  import mpsa_pkg::*;

  localparam int PW  = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int PXW = (PW > 3) ? PW : 3;
  localparam int PP  = 1 << PW;
  localparam int DW  = $clog2(SLOTS);
  localparam int BW  = $clog2(SLOTS + 1);
  localparam int NW  = 5;
  localparam logic [NW-1:0] POOLS_N = NW'(POOLS);
  localparam logic [BW-1:0] SLOTS_B = BW'(SLOTS);

  logic [3:0]    pools_in_use_q;
  req_t          req_q;
  logic          req_v_q;
  logic [BW-1:0] bump_q  [POOLS];
  logic [BW-1:0] depth_q [POOLS];

  logic [NW-1:0]  n;
  logic [BW-1:0]  node_val [2*PP];
  logic [PW-1:0]  node_idx [2*PP];
  logic           node_ok  [2*PP];
  logic           fire, is_auto, in_use;
  logic [PXW-1:0] pool_ext;
  logic [PW-1:0]  sel;
  logic [BW-1:0]  b, d, a, a_inc, a_dec, d_dec, d_inc;
  logic           bump_inc, depth_dec, depth_inc;

  assign fire       = req_v_q && !cmd_full_i;
  assign full_o     = req_v_q && cmd_full_i;
  assign cmd_push_o = fire;

  // register values above POOLS act as POOLS
  assign n = ({1'b0, pools_in_use_q} > POOLS_N) ? POOLS_N : {1'b0, pools_in_use_q};

  // min tree over active counts, lower index wins ties
  always_comb begin
    for (int i = 0; i < PP; i++) begin
      node_idx[PP+i] = PW'(i);
      if (i < POOLS) begin
        node_ok[PP+i]  = (NW'(i) < n);
        node_val[PP+i] = bump_q[i] - depth_q[i];
      end else begin
        node_ok[PP+i]  = 1'b0;
        node_val[PP+i] = '0;
      end
    end
    node_idx[0] = '0;
    node_ok[0]  = 1'b0;
    node_val[0] = '0;
    for (int k = PP - 1; k >= 1; k--) begin
      if (node_ok[2*k+1] && (!node_ok[2*k] || (node_val[2*k+1] < node_val[2*k]))) begin
        node_idx[k] = node_idx[2*k+1];
        node_val[k] = node_val[2*k+1];
        node_ok[k]  = 1'b1;
      end else begin
        node_idx[k] = node_idx[2*k];
        node_val[k] = node_val[2*k];
        node_ok[k]  = node_ok[2*k];
      end
    end
  end

  always_comb begin
    is_auto  = (req_q.operation == OP_ALLOC) && req_q.auto_pool;
    pool_ext = PXW'(req_q.pool);
    sel      = is_auto ? node_idx[1] : pool_ext[PW-1:0];
    in_use   = is_auto ? (n != '0) : ({{(NW-PXW){1'b0}}, pool_ext} < n);
    b        = bump_q[sel];
    d        = depth_q[sel];
    a        = b - d;
    a_inc    = a + BW'(1);
    a_dec    = a - BW'(1);
    d_dec    = d - BW'(1);
    d_inc    = d + BW'(1);

    bump_inc  = 1'b0;
    depth_dec = 1'b0;
    depth_inc = 1'b0;

    cmd_o                  = '0;
    cmd_o.kind             = CMD_NONE;
    cmd_o.wdata            = req_q.slot;
    cmd_o.rsp.granted_pool = 3'(sel);

    if (!in_use) begin
      cmd_o.rsp.status       = STAT_NOT_IN_USE;
      cmd_o.rsp.granted_pool = is_auto ? 3'd0 : req_q.pool;
    end else if (req_q.operation == OP_ALLOC) begin
      if (b < SLOTS_B) begin
        bump_inc               = 1'b1;
        cmd_o.rsp.status       = STAT_OK;
        cmd_o.rsp.granted_slot = 8'(b);
        cmd_o.rsp.active_count = 9'(a_inc);
      end else if (d != '0) begin
        // slot comes back from the stack in the back end
        depth_dec              = 1'b1;
        cmd_o.kind             = CMD_READ;
        cmd_o.addr             = CMD_AW'({sel, d_dec[DW-1:0]});
        cmd_o.rsp.status       = STAT_OK;
        cmd_o.rsp.active_count = 9'(a_inc);
      end else begin
        cmd_o.rsp.status       = STAT_EXHAUSTED;
        cmd_o.rsp.active_count = 9'(a);
      end
    end else begin
      if (a == '0) begin
        cmd_o.rsp.status = STAT_FREE_REJECTED;
      end else begin
        depth_inc              = 1'b1;
        cmd_o.kind             = CMD_WRITE;
        cmd_o.addr             = CMD_AW'({sel, d[DW-1:0]});
        cmd_o.rsp.status       = STAT_OK;
        cmd_o.rsp.active_count = 9'(a_dec);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pools_in_use_q <= POOLS_IN_USE_RST;
      req_v_q        <= 1'b0;
      for (int i = 0; i < POOLS; i++) begin
        bump_q[i]  <= '0;
        depth_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        pools_in_use_q <= cfg_wdata_i;
      end
      if (push_i && !full_o) begin
        req_v_q <= 1'b1;
      end else if (fire) begin
        req_v_q <= 1'b0;
      end
      if (fire && in_use) begin
        if (bump_inc) begin
          bump_q[sel] <= a_inc + d;
        end
        if (depth_dec) begin
          depth_q[sel] <= d_dec;
        end else if (depth_inc) begin
          depth_q[sel] <= d_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      req_q <= req_i;
    end
  end

endmodule

@@ rtl/mpsa_back.sv @@
module mpsa_back #(
  parameter int POOLS = 8,
  parameter int SLOTS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mpsa_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           out_full_i,
  output logic           out_push_o,
  output mpsa_pkg::rsp_t out_o
);
  import mpsa_pkg::*;

  localparam int PW   = (POOLS > 1) ? $clog2(POOLS) : 1;
  localparam int DW   = $clog2(SLOTS);
  localparam int AW   = PW + DW;
  localparam int MEMD = 1 << AW;

  localparam logic BK_IDLE = 1'b0;
  localparam logic BK_WAIT = 1'b1;

  logic [7:0] stack_q [MEMD];
  logic [7:0] rdata_q;
  rsp_t       held_q;
  logic       state_q, state_d;
  logic       mem_re, mem_we;

  always_comb begin
    state_d    = state_q;
    cmd_pop_o  = 1'b0;
    out_push_o = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    out_o      = cmd_i.rsp;
    unique case (state_q)
      BK_IDLE: begin
        // room in the result queue is claimed here, also for the read case
        if (!cmd_empty_i && !out_full_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = BK_WAIT;
            end
            CMD_WRITE: begin
              mem_we     = 1'b1;
              out_push_o = 1'b1;
            end
            default: begin
              out_push_o = 1'b1;
            end
          endcase
        end
      end
      BK_WAIT: begin
        out_o              = held_q;
        out_o.granted_slot = rdata_q;
        out_push_o         = 1'b1;
        state_d            = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_q[cmd_i.addr[AW-1:0]] <= cmd_i.wdata;
    end
    if (mem_re) begin
      rdata_q <= stack_q[cmd_i.addr[AW-1:0]];
      held_q  <= cmd_i.rsp;
    end
  end

endmodule

@@ rtl/multi_pool_slot_allocator.sv @@
// channel  | direction | handshake             | payload
// ---------+-----------+-----------------------+-------------------------------
// request  | in        | push / full           | req_i  (operation, auto_pool,
//          |           |                       |         pool, slot)
// result   | out       | empty / pop           | rsp_o  (status, granted_pool,
//          |           |                       |         granted_slot, active_count)
// config   | in        | cfg_we_i              | cfg_wdata_i (pools_in_use)
//
// The front end classifies one request per cycle while the command queue has room
// and updates the pool counters; the back end handles a request in its idle state,
// and a free-stack pop adds a wait state for the registered memory read.
// Reset clears counters and sets pools_in_use to 8 at once; the free stack is not cleared.
// Full rises only when the command queue fills; a stalled pop backs up through
// the result queue, the back end and the command queue.
module multi_pool_slot_allocator #(
  parameter int POOLS = 8,
  parameter int SLOTS = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i,
  input  logic           push,
  input  mpsa_pkg::req_t req_i,
  output logic           full,
  output logic           empty,
  input  logic           pop,
  output mpsa_pkg::rsp_t rsp_o
);
  import mpsa_pkg::*;

  cmd_t front_cmd, back_cmd;
  rsp_t back_rsp;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic out_push, out_full;

  mpsa_front #(
    .POOLS(POOLS),
    .SLOTS(SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push_i     (push),
    .req_i      (req_i),
    .full_o     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (cmd_full)
  );

  mpsa_fifo #(
    .T    (cmd_t),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (back_cmd),
    .empty_o(cmd_empty)
  );

  mpsa_back #(
    .POOLS(POOLS),
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_o      (back_rsp)
  );

  mpsa_fifo #(
    .T    (rsp_t),
    .DEPTH(2)
  ) u_rsp_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (back_rsp),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (rsp_o),
    .empty_o(empty)
  );

endmodule

@@ sim/mpsa_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels and the pools_in_use write port, tracks the allocator
// state and compares every popped result against the predicted one.
module mpsa_checker #(
  parameter int POOLS = 8,
  parameter int SLOTS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             push,
  input  logic             full,
  input  mpsa_pkg::req_t   req_i,
  input  logic             empty,
  input  logic             pop,
  input  mpsa_pkg::rsp_t   rsp_i,
  output int               fail_count_o,
  output int               waiting_o
);
  import mpsa_pkg::*;

  logic [3:0] pools_in_use;
  logic [8:0] bump_index [POOLS];
  logic [8:0] free_depth [POOLS];
  logic [7:0] freed_slots [POOLS][SLOTS];
  rsp_t       grant_q [$];

  function automatic logic [8:0] load(input int p);
    return bump_index[p] - free_depth[p];
  endfunction

  // Applies one request to the tracked pools and returns its result.
  function automatic rsp_t grant(input req_t r);
    rsp_t g;
    int   span;
    int   p;
    g = '0;
    span = (pools_in_use > POOLS) ? POOLS : pools_in_use;
    p = int'(r.pool);
    if (r.operation == OP_ALLOC && r.auto_pool) begin
      if (span == 0) begin
        g.status = STAT_NOT_IN_USE;
        return g;
      end
      // least loaded pool, lowest index on a tie
      p = 0;
      for (int i = 1; i < span; i++)
        if (load(i) < load(p)) p = i;
    end
    g.granted_pool = p[2:0];
    if (p >= span) begin
      g.status = STAT_NOT_IN_USE;
      return g;
    end
    if (r.operation == OP_ALLOC) begin
      if (bump_index[p] < SLOTS) begin
        g.granted_slot = bump_index[p][7:0];
        bump_index[p]++;
      end else if (free_depth[p] != 0) begin
        free_depth[p]--;
        g.granted_slot = freed_slots[p][free_depth[p]];
      end else begin
        g.status = STAT_EXHAUSTED;
        g.active_count = load(p);
        return g;
      end
      g.status = STAT_OK;
      g.active_count = load(p);
    end else if (load(p) == 0) begin
      g.status = STAT_FREE_REJECTED;
    end else begin
      freed_slots[p][free_depth[p]] = r.slot;
      free_depth[p]++;
      g.status = STAT_OK;
      g.active_count = load(p);
    end
    return g;
  endfunction

  task automatic check_field(input string field, input logic [8:0] want_v, got_v);
    if (got_v !== want_v) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      pools_in_use = POOLS_IN_USE_RST;
      for (int i = 0; i < POOLS; i++) begin
        bump_index[i] = '0;
        free_depth[i] = '0;
      end
      grant_q.delete();
      fail_count_o = 0;
      waiting_o = 0;
    end else begin
      if (cfg_we_i) pools_in_use = cfg_wdata_i;
      if (push && !full) grant_q.insert(grant_q.size(), grant(req_i));
      if (pop && !empty) begin
        if (grant_q.size() == 0) begin
          $display("%0t ns: result expected none, got %p", $time, rsp_i);
          fail_count_o++;
        end else begin
          want = grant_q.pop_front();
          check_field("status", 9'(want.status), 9'(rsp_i.status));
          check_field("granted_pool", 9'(want.granted_pool), 9'(rsp_i.granted_pool));
          check_field("granted_slot", 9'(want.granted_slot), 9'(rsp_i.granted_slot));
          check_field("active_count", want.active_count, rsp_i.active_count);
        end
      end
      waiting_o = grant_q.size();
    end
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mpsa_pkg::*;

  localparam int POOLS        = 8;
  localparam int SLOTS        = 256;
  localparam int HOLD_CYCLES  = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 12;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [3:0] cfg_wdata = '0;
  logic       push = 1'b0;
  req_t       req = '0;
  logic       full;
  logic       empty;
  logic       pop = 1'b0;
  rsp_t       rsp;
  int         fail_count;
  int         waiting;
  bit         bursty = 1'b1;
  bit         rx_hold = 1'b0;
  int         quiet_cycles = 0;

  always #5 clk = ~clk;

  multi_pool_slot_allocator #(
    .POOLS(POOLS),
    .SLOTS(SLOTS)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push       (push),
    .req_i      (req),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .rsp_o      (rsp)
  );

  mpsa_checker #(
    .POOLS(POOLS),
    .SLOTS(SLOTS)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .push        (push),
    .full        (full),
    .req_i       (req),
    .empty       (empty),
    .pop         (pop),
    .rsp_i       (rsp),
    .fail_count_o(fail_count),
    .waiting_o   (waiting)
  );

  // no request moving in either direction for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("multi_pool_slot_allocator: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side: random stall bursts, plus one long hold-off on demand
  initial begin
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
        pop <= 1'b1;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic req_t mk(input logic op, autop, input logic [2:0] p,
                              input logic [7:0] s);
    req_t r;
    r.operation = op;
    r.auto_pool = autop;
    r.pool = p;
    r.slot = s;
    return r;
  endfunction

  task automatic send(input req_t r);
    int gap;
    if (bursty && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    push <= 1'b1;
    req <= r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    push <= 1'b0;
    wait (waiting == 0);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_pools(input logic [3:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random requests; most target pools in use, a few any index
  task automatic run_phase(input logic [3:0] v, input int count, alloc_pct, hold_at);
    int   span;
    req_t r;
    set_pools(v);
    span = (v > POOLS) ? POOLS : v;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) rx_hold = 1'b1;
      r.operation = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
      r.auto_pool = ($urandom_range(0, 2) == 0);
      if (span > 0 && $urandom_range(0, 7) != 0) r.pool = 3'($urandom_range(0, span - 1));
      else r.pool = 3'($urandom_range(0, 7));
      r.slot = 8'($urandom_range(0, 255));
      send(r);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset setting: all pools open
    send(mk(OP_FREE,  1'b0, 3'd0, 8'd0));    // nothing active, refused
    send(mk(OP_ALLOC, 1'b1, 3'd6, 8'hff));   // auto picks pool 0
    send(mk(OP_ALLOC, 1'b0, 3'd7, 8'd0));
    send(mk(OP_ALLOC, 1'b1, 3'd0, 8'd0));    // tie between 1..6, lowest wins
    send(mk(OP_FREE,  1'b0, 3'd7, 8'hff));
    send(mk(OP_ALLOC, 1'b0, 3'd7, 8'h55));
    send(mk(OP_FREE,  1'b1, 3'd0, 8'haa));
    send(mk(OP_FREE,  1'b0, 3'd0, 8'h01));   // pool 0 back to zero, refused
    send(mk(OP_ALLOC, 1'b1, 3'd3, 8'h00));

    // no pools open
    set_pools(4'd0);
    send(mk(OP_ALLOC, 1'b1, 3'd4, 8'd0));
    send(mk(OP_ALLOC, 1'b0, 3'd5, 8'd9));
    send(mk(OP_FREE,  1'b0, 3'd3, 8'd1));

    // oversized setting acts as all pools
    set_pools(4'd15);
    send(mk(OP_ALLOC, 1'b0, 3'd7, 8'd0));
    send(mk(OP_ALLOC, 1'b1, 3'd2, 8'd0));
    send(mk(OP_FREE,  1'b0, 3'd7, 8'h80));

    // single pool open
    set_pools(4'd1);
    send(mk(OP_ALLOC, 1'b0, 3'd1, 8'd0));
    send(mk(OP_FREE,  1'b0, 3'd4, 8'd7));
    send(mk(OP_ALLOC, 1'b1, 3'd7, 8'd0));

    // pool 0 runs past its bump range into exhaustion and stack reuse
    run_phase(4'd1, 420, 90, -1);
    run_phase(4'd2, 300, 60, -1);
    run_phase(4'd8, 250, 55, 100);
    run_phase(4'd3, 250, 55, -1);
    run_phase(4'd0, 40, 50, -1);
    run_phase(4'd15, 200, 50, -1);
    run_phase(4'd5, 200, 55, -1);
    bursty = 1'b0;
    run_phase(4'd1, 190, 45, -1);

    drain();
    if (fail_count == 0) begin
      $display("multi_pool_slot_allocator: match");
    end else begin
      $display("multi_pool_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule
